FILE: rtl/tlrq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Three-level run queue dispatch: shared definitions
// Types, codes and reset values that the front, the command queue, the back
// end and the top level all use.
// ----------------------------------------------------------------------------
package tlrq_pkg;

	// Sizes.
	localparam int QUEUE_DEPTH = 512;
	localparam int NUM_LEVELS  = 3;
	localparam logic [7:0] PRIO_TOP = 8'd140;

	// Request kinds.
	localparam logic REQ_ENQ  = 1'b0;
	localparam logic REQ_DISP = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_ENQUEUED   = 2'd0;
	localparam logic [1:0] ST_DROPPED    = 2'd1;
	localparam logic [1:0] ST_DISPATCHED = 2'd2;
	localparam logic [1:0] ST_NONE_READY = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_LEVEL0_LIMIT  = 3'd0;
	localparam logic [2:0] REG_LEVEL1_LIMIT  = 3'd1;
	localparam logic [2:0] REG_LONG_Q_LIMIT  = 3'd2;
	localparam logic [2:0] REG_LARGE_UNIT    = 3'd3;
	localparam logic [2:0] REG_SMALL_UNIT    = 3'd4;
	localparam logic [2:0] REG_FULL_BONUS    = 3'd5;
	localparam logic [2:0] REG_PARTIAL_BONUS = 3'd6;

	// Configuration reset values.
	localparam logic [7:0] RST_LEVEL0_LIMIT  = 8'd100;
	localparam logic [7:0] RST_LEVEL1_LIMIT  = 8'd130;
	localparam logic [7:0] RST_LONG_Q_LIMIT  = 8'd120;
	localparam logic [5:0] RST_LARGE_UNIT    = 6'd20;
	localparam logic [5:0] RST_SMALL_UNIT    = 6'd5;
	localparam logic [4:0] RST_FULL_BONUS    = 5'd10;
	localparam logic [4:0] RST_PARTIAL_BONUS = 5'd5;

	// A classified request as it travels from the front to the back end.
	typedef struct packed {
		logic        req;
		logic [1:0]  lvl;
		logic [14:0] task_id;
		logic [7:0]  base_prio;
		logic [7:0]  run_prio;
		logic [15:0] time_left;
		logic [1:0]  policy;
		logic [6:0]  exec_time;
	} cmd_t;

	// A stored task record.
	typedef struct packed {
		logic [14:0] task_id;
		logic [7:0]  base_prio;
		logic [7:0]  run_prio;
		logic [15:0] time_left;
		logic [1:0]  policy;
	} rec_t;

	// Settings the back end needs for the quantum and bonus.
	typedef struct packed {
		logic [7:0] long_q_limit;
		logic [5:0] large_unit;
		logic [5:0] small_unit;
		logic [4:0] full_bonus;
		logic [4:0] partial_bonus;
	} sched_cfg_t;

	// One result.
	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  level;
		logic [14:0] task_id;
		logic [7:0]  base_prio;
		logic [7:0]  run_prio;
		logic [15:0] time_left;
		logic [1:0]  policy;
		logic [13:0] quantum;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/three_level_run_queue_dispatch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Three-level run queue dispatch
// An enqueue passes the front register, a queue entry and the result register;
// a dispatch adds the record memory read, quantum multiply and bonus add.
// Throughput: one enqueue per cycle while no dispatch holds the back end. The
// receiver cannot stall; busy rises only when the command queue is full.
// Reset clears all queues (empty levels) and loads the register defaults.
// ----------------------------------------------------------------------------
module three_level_run_queue_dispatch #(
	parameter int QUEUE_DEPTH = tlrq_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [14:0] task_id,
	input  logic [7:0]  base_prio,
	input  logic [7:0]  run_prio,
	input  logic [15:0] time_left,
	input  logic [1:0]  policy_kind,
	input  logic [6:0]  exec_time,
	output logic        done,
	output logic [1:0]  status,
	output logic [1:0]  level,
	output logic [14:0] out_task_id,
	output logic [7:0]  out_base_prio,
	output logic [7:0]  out_run_prio,
	output logic [15:0] out_time_left,
	output logic [1:0]  out_policy,
	output logic [13:0] quantum,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [7:0]  wr_data
);

	logic [7:0]           level0_limit_q;
	logic [7:0]           level1_limit_q;
	tlrq_pkg::sched_cfg_t cfg_q;
	logic                 q_push;
	tlrq_pkg::cmd_t       q_push_cmd;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_empty;
	tlrq_pkg::cmd_t       q_head;
	tlrq_pkg::result_t    res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level0_limit_q      <= tlrq_pkg::RST_LEVEL0_LIMIT;
			level1_limit_q      <= tlrq_pkg::RST_LEVEL1_LIMIT;
			cfg_q.long_q_limit  <= tlrq_pkg::RST_LONG_Q_LIMIT;
			cfg_q.large_unit    <= tlrq_pkg::RST_LARGE_UNIT;
			cfg_q.small_unit    <= tlrq_pkg::RST_SMALL_UNIT;
			cfg_q.full_bonus    <= tlrq_pkg::RST_FULL_BONUS;
			cfg_q.partial_bonus <= tlrq_pkg::RST_PARTIAL_BONUS;
		end else if (wr_en) begin
			case (wr_index)
				tlrq_pkg::REG_LEVEL0_LIMIT:  level0_limit_q      <= wr_data;
				tlrq_pkg::REG_LEVEL1_LIMIT:  level1_limit_q      <= wr_data;
				tlrq_pkg::REG_LONG_Q_LIMIT:  cfg_q.long_q_limit  <= wr_data;
				tlrq_pkg::REG_LARGE_UNIT:    cfg_q.large_unit    <= wr_data[5:0];
				tlrq_pkg::REG_SMALL_UNIT:    cfg_q.small_unit    <= wr_data[5:0];
				tlrq_pkg::REG_FULL_BONUS:    cfg_q.full_bonus    <= wr_data[4:0];
				tlrq_pkg::REG_PARTIAL_BONUS: cfg_q.partial_bonus <= wr_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: accept and classify.
	tlrq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.task_id      (task_id),
		.base_prio    (base_prio),
		.run_prio     (run_prio),
		.time_left    (time_left),
		.policy_kind  (policy_kind),
		.exec_time    (exec_time),
		.level0_limit (level0_limit_q),
		.level1_limit (level1_limit_q),
		.q_full       (q_full),
		.push         (q_push),
		.push_cmd     (q_push_cmd)
	);

	// Command queue between the two halves.
	tlrq_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	// Back end: run queues and result.
	tlrq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.pop     (q_pop),
		.cfg     (cfg_q),
		.done    (done),
		.res     (res)
	);

	assign status        = res.status;
	assign level         = res.level;
	assign out_task_id   = res.task_id;
	assign out_base_prio = res.base_prio;
	assign out_run_prio  = res.run_prio;
	assign out_time_left = res.time_left;
	assign out_policy    = res.policy;
	assign quantum       = res.quantum;

	// A result never names a level beyond the third.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (level != 2'd3))
		else $error("result level out of range");

	// Enqueue results carry no record and no quantum.
	a_enq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == tlrq_pkg::ST_ENQUEUED || status == tlrq_pkg::ST_DROPPED)
		|-> (out_task_id == '0 && out_run_prio == '0 && quantum == '0))
		else $error("enqueue result carries record data");

	// An empty dispatch reports nothing but its status.
	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == tlrq_pkg::ST_NONE_READY)
		|-> (level == '0 && out_task_id == '0 && out_time_left == '0 && quantum == '0))
		else $error("empty dispatch result carries data");

endmodule
`default_nettype wire

FILE: rtl/tlrq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, picks the queue level from the static priority and holds
// the classified request until the command queue takes it.
// ----------------------------------------------------------------------------
module tlrq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              req_type,
	input  logic [14:0]       task_id,
	input  logic [7:0]        base_prio,
	input  logic [7:0]        run_prio,
	input  logic [15:0]       time_left,
	input  logic [1:0]        policy_kind,
	input  logic [6:0]        exec_time,
	input  logic [7:0]        level0_limit,
	input  logic [7:0]        level1_limit,
	input  logic              q_full,
	output logic              push,
	output tlrq_pkg::cmd_t    push_cmd
);

	logic           valid_s1;
	tlrq_pkg::cmd_t cmd_s1;
	logic           accept;
	logic [1:0]     lvl;

	// The stage stalls only when the queue cannot take its request.
	assign push   = valid_s1 && !q_full;
	assign busy   = valid_s1 && q_full;
	assign accept = start && !busy;
	assign push_cmd = cmd_s1;

	// Level from the two priority limits.
	always_comb begin
		if (base_prio < level0_limit) begin
			lvl = 2'd0;
		end else if (base_prio < level1_limit) begin
			lvl = 2'd1;
		end else begin
			lvl = 2'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= '{req: req_type, lvl: lvl, task_id: task_id,
				base_prio: base_prio, run_prio: run_prio, time_left: time_left,
				policy: policy_kind, exec_time: exec_time};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/tlrq_cmdq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// A two-entry queue between the front end and the back end so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module tlrq_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tlrq_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output tlrq_pkg::cmd_t head
);

	tlrq_pkg::cmd_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/tlrq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Run queue back end
// Holds the three run queues in one record memory, carries out enqueue and
// dispatch requests and forms the registered result.
// ----------------------------------------------------------------------------
module tlrq_back #(
	parameter int QUEUE_DEPTH = tlrq_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  tlrq_pkg::cmd_t       q_head,
	output logic                 pop,
	input  tlrq_pkg::sched_cfg_t cfg,
	output logic                 done,
	output tlrq_pkg::result_t    res
);

	localparam int NL = tlrq_pkg::NUM_LEVELS;
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int MD = NL * QUEUE_DEPTH;
	localparam int MW = $clog2(MD);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [PW-1:0]    head_q [NL];
	logic [PW-1:0]    tail_q [NL];
	logic [CW-1:0]    fill_q [NL];
	tlrq_pkg::rec_t   mem [MD];
	tlrq_pkg::rec_t   rd_q;
	logic [1:0]       lvl_q;
	logic [6:0]       exec_q;
	logic [13:0]      quantum_q;
	logic             done_q;
	tlrq_pkg::result_t res_q;

	logic             found;
	logic [1:0]       dlvl;
	logic [1:0]       sel_lvl;
	logic [PW-1:0]    sel_head;
	logic [PW-1:0]    sel_tail;
	logic [CW-1:0]    sel_fill;
	logic             is_enq;
	logic             lvl_full;
	logic             do_write;
	logic             do_read;
	logic [MW-1:0]    lvl_base;
	logic [MW-1:0]    wr_addr;
	logic [MW-1:0]    rd_addr;
	logic [7:0]       diff;
	logic [5:0]       unit;
	logic [4:0]       bonus;
	logic [8:0]       prio_sum;
	logic [7:0]       prio;
	tlrq_pkg::result_t res_short;

	assign pop  = (state_q == S_IDLE) && !q_empty;
	assign done = done_q;
	assign res  = res_q;

	// Lowest non-empty level for a dispatch.
	always_comb begin
		found = 1'b1;
		if (fill_q[0] != '0) begin
			dlvl = 2'd0;
		end else if (fill_q[1] != '0) begin
			dlvl = 2'd1;
		end else if (fill_q[2] != '0) begin
			dlvl = 2'd2;
		end else begin
			dlvl  = 2'd0;
			found = 1'b0;
		end
	end

	// Pointers and count of the level this request works on.
	always_comb begin
		sel_lvl  = (q_head.req == tlrq_pkg::REQ_ENQ) ? q_head.lvl : dlvl;
		sel_head = '0;
		sel_tail = '0;
		sel_fill = '0;
		for (int i = 0; i < NL; i++) begin
			if (sel_lvl == 2'(i)) begin
				sel_head = head_q[i];
				sel_tail = tail_q[i];
				sel_fill = fill_q[i];
			end
		end
	end

	assign is_enq   = pop && (q_head.req == tlrq_pkg::REQ_ENQ);
	assign lvl_full = (sel_fill == CW'(QUEUE_DEPTH));
	assign do_write = is_enq && !lvl_full;
	assign do_read  = pop && (q_head.req == tlrq_pkg::REQ_DISP) && found;
	assign lvl_base = MW'(sel_lvl) * MW'(QUEUE_DEPTH);
	assign wr_addr  = lvl_base + MW'(sel_tail);
	assign rd_addr  = lvl_base + MW'(sel_head);

	// Queue pointers and fill counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NL; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NL; i++) begin
				if (sel_lvl == 2'(i)) begin
					if (do_write) begin
						tail_q[i] <= (tail_q[i] == PW'(QUEUE_DEPTH - 1)) ? '0
							: tail_q[i] + PW'(1);
						fill_q[i] <= fill_q[i] + CW'(1);
					end
					if (do_read) begin
						head_q[i] <= (head_q[i] == PW'(QUEUE_DEPTH - 1)) ? '0
							: head_q[i] + PW'(1);
						fill_q[i] <= fill_q[i] - CW'(1);
					end
				end
			end
		end
	end

	// Record memory with registered read data.
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_addr] <= '{task_id: q_head.task_id, base_prio: q_head.base_prio,
				run_prio: q_head.run_prio, time_left: q_head.time_left,
				policy: q_head.policy};
		end
		if (do_read) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Quantum factors from the popped record.
	assign diff = (rd_q.base_prio < tlrq_pkg::PRIO_TOP) ?
		(tlrq_pkg::PRIO_TOP - rd_q.base_prio) : 8'd0;
	assign unit = (rd_q.base_prio < cfg.long_q_limit) ? cfg.large_unit : cfg.small_unit;

	// Bonus and saturating dynamic priority.
	assign bonus    = (14'(exec_q) < quantum_q) ? cfg.full_bonus : cfg.partial_bonus;
	assign prio_sum = {1'b0, rd_q.run_prio} + 9'(bonus);
	assign prio     = prio_sum[8] ? 8'hFF : prio_sum[7:0];

	// Result of a request that finishes at once: an enqueue or an empty dispatch.
	always_comb begin
		res_short = '0;
		if (is_enq) begin
			res_short.status = lvl_full ? tlrq_pkg::ST_DROPPED : tlrq_pkg::ST_ENQUEUED;
			res_short.level  = sel_lvl;
		end else begin
			res_short.status = tlrq_pkg::ST_NONE_READY;
		end
	end

	// Sequencer and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (pop && !do_read) || (state_q == S_FIN);
			case (state_q)
				S_IDLE: begin
					if (do_read) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers and the result.
	always_ff @(posedge clk) begin
		if (do_read) begin
			lvl_q  <= sel_lvl;
			exec_q <= q_head.exec_time;
		end
		if (state_q == S_MUL) begin
			quantum_q <= 14'(diff) * 14'(unit);
		end
		if (pop && !do_read) begin
			res_q <= res_short;
		end else if (state_q == S_FIN) begin
			res_q <= '{status: tlrq_pkg::ST_DISPATCHED, level: lvl_q,
				task_id: rd_q.task_id, base_prio: rd_q.base_prio, run_prio: prio,
				time_left: rd_q.time_left, policy: rd_q.policy, quantum: quantum_q};
		end
	end

endmodule
`default_nettype wire

FILE: tb/three_level_run_queue_dispatch_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Three-level run queue dispatch: self-checking testbench
// Drives enqueue and dispatch requests through the command port and keeps a
// model of the three run queues and the scheduling registers. Each result is
// checked field by field against the oldest expected result. A short table
// of hand-picked requests runs first. Random phases follow, all but the first
// under new register settings, each with its own request mix and sender idle
// rate. One phase fills a level past its depth so that requests are dropped.
// ----------------------------------------------------------------------------
module three_level_run_queue_dispatch_tb;
	import tlrq_pkg::*;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int N_DIRECTED = 22;
	localparam int N_PHASES   = 6;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic        req_type;
		logic [14:0] task_id;
		logic [7:0]  base_prio;
		logic [7:0]  run_prio;
		logic [15:0] time_left;
		logic [1:0]  policy_kind;
		logic [6:0]  exec_time;
	} request_t;

	typedef struct {
		request_t req;
		bit       typed;
		result_t  want;
	} stim_row_t;

	typedef struct {
		logic [7:0] level0_limit;
		logic [7:0] level1_limit;
		logic [7:0] long_q_limit;
		logic [5:0] large_unit;
		logic [5:0] small_unit;
		logic [4:0] full_bonus;
		logic [4:0] partial_bonus;
	} sched_regs_t;

	typedef enum {CFG_KEEP, CFG_MAX, CFG_ZERO, CFG_FILL, CFG_RANDOM} settings_kind_e;

	typedef struct {
		settings_kind_e kind;
		int             count;
		int             enq_pct;
		int             idle_pct;
	} phase_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        req_type;
	logic [14:0] task_id;
	logic [7:0]  base_prio;
	logic [7:0]  run_prio;
	logic [15:0] time_left;
	logic [1:0]  policy_kind;
	logic [6:0]  exec_time;
	logic        done;
	logic [1:0]  status;
	logic [1:0]  level;
	logic [14:0] out_task_id;
	logic [7:0]  out_base_prio;
	logic [7:0]  out_run_prio;
	logic [15:0] out_time_left;
	logic [1:0]  out_policy;
	logic [13:0] quantum;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [7:0]  wr_data;

	// Model state: the three run queues and the scheduling registers.
	rec_t        run_store [NUM_LEVELS][QUEUE_DEPTH];
	int          head_slot [NUM_LEVELS];
	int          tail_slot [NUM_LEVELS];
	int          fill_level [NUM_LEVELS];
	sched_regs_t sched_regs;

	result_t pending_results [$];
	int      fail_count;

	// Hand-picked requests under the reset settings: empty dispatch, level
	// boundaries, priorities above 140, policy code 3, saturation and the
	// execution time right at the quantum.
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 0}, 1, '{ST_NONE_READY, 0, 0, 0, 0, 0, 0, 0}},
		'{'{REQ_ENQ, 'h7fff, 0, 255, 'hffff, 3, 0}, 1, '{ST_ENQUEUED, 0, 0, 0, 0, 0, 0, 0}},
		'{'{REQ_ENQ, 0, 99, 0, 0, 0, 0}, 1, '{ST_ENQUEUED, 0, 0, 0, 0, 0, 0, 0}},
		'{'{REQ_ENQ, 1, 100, 250, 1, 1, 0}, 1, '{ST_ENQUEUED, 1, 0, 0, 0, 0, 0, 0}},
		'{'{REQ_ENQ, 2, 129, 128, 2, 2, 0}, 1, '{ST_ENQUEUED, 1, 0, 0, 0, 0, 0, 0}},
		'{'{REQ_ENQ, 3, 130, 7, 'h8000, 2, 0}, 1, '{ST_ENQUEUED, 2, 0, 0, 0, 0, 0, 0}},
		'{'{REQ_ENQ, 4, 139, 1, 100, 0, 0}, 1, '{ST_ENQUEUED, 2, 0, 0, 0, 0, 0, 0}},
		'{'{REQ_ENQ, 5, 140, 200, 5, 1, 0}, 1, '{ST_ENQUEUED, 2, 0, 0, 0, 0, 0, 0}},
		'{'{REQ_ENQ, 6, 255, 254, 6, 3, 0}, 1, '{ST_ENQUEUED, 2, 0, 0, 0, 0, 0, 0}},
		'{'{REQ_ENQ, 'h4000, 119, 251, 7, 0, 0}, 1, '{ST_ENQUEUED, 1, 0, 0, 0, 0, 0, 0}},
		'{'{REQ_ENQ, 'h2aaa, 120, 246, 'h5555, 1, 0}, 1,
			'{ST_ENQUEUED, 1, 0, 0, 0, 0, 0, 0}},
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 127}, 1,
			'{ST_DISPATCHED, 0, 'h7fff, 0, 255, 'hffff, 3, 2800}},
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 0}, 0, '0},
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 127}, 0, '0},
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 55}, 0, '0},
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 127}, 0, '0},
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 100}, 0, '0},
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 4}, 0, '0},
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 5}, 0, '0},
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 0}, 0, '0},
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 0}, 0, '0},
		'{'{REQ_DISP, 0, 0, 0, 0, 0, 127}, 1, '{ST_NONE_READY, 0, 0, 0, 0, 0, 0, 0}}
	};

	// Random phases. The fill phase routes every request to level two and
	// overruns it; the phase after it mostly drains the queues.
	phase_t phases [N_PHASES] = '{
		'{CFG_KEEP, 200, 55, 0},
		'{CFG_MAX, 200, 50, 71},
		'{CFG_ZERO, 150, 50, 21},
		'{CFG_FILL, 600, 95, 0},
		'{CFG_RANDOM, 250, 15, 71},
		'{CFG_RANDOM, 200, 50, 21}
	};

	three_level_run_queue_dispatch dut (.*);

	// Clock with an 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Scheduler model: applies one accepted request and returns its result.
	function automatic result_t schedule_request(input request_t r);
		result_t res;
		rec_t    rec;
		int      lvl;
		int      diff;
		int      slice;
		int      prio;
		res = '0;
		if (r.req_type == REQ_ENQ) begin
			if (r.base_prio < sched_regs.level0_limit)
				lvl = 0;
			else if (r.base_prio < sched_regs.level1_limit)
				lvl = 1;
			else
				lvl = 2;
			res.level = lvl[1:0];
			if (fill_level[lvl] >= QUEUE_DEPTH) begin
				res.status = ST_DROPPED;
			end else begin
				rec = '{r.task_id, r.base_prio, r.run_prio, r.time_left, r.policy_kind};
				run_store[lvl][tail_slot[lvl]] = rec;
				tail_slot[lvl] = (tail_slot[lvl] + 1 >= QUEUE_DEPTH) ? 0 : tail_slot[lvl] + 1;
				fill_level[lvl]++;
				res.status = ST_ENQUEUED;
			end
			return res;
		end

		// Dispatch takes the oldest task of the lowest non-empty level.
		lvl = 0;
		while (lvl < NUM_LEVELS && fill_level[lvl] == 0)
			lvl++;
		if (lvl == NUM_LEVELS) begin
			res.status = ST_NONE_READY;
			return res;
		end
		rec = run_store[lvl][head_slot[lvl]];
		head_slot[lvl] = (head_slot[lvl] + 1 >= QUEUE_DEPTH) ? 0 : head_slot[lvl] + 1;
		fill_level[lvl]--;

		diff = (rec.base_prio < PRIO_TOP) ? int'(PRIO_TOP) - int'(rec.base_prio) : 0;
		slice = diff * ((rec.base_prio < sched_regs.long_q_limit) ?
			int'(sched_regs.large_unit) : int'(sched_regs.small_unit));
		prio = int'(rec.run_prio) + ((int'(r.exec_time) < slice) ?
			int'(sched_regs.full_bonus) : int'(sched_regs.partial_bonus));
		if (prio > 255)
			prio = 255;

		res.status    = ST_DISPATCHED;
		res.level     = lvl[1:0];
		res.task_id   = rec.task_id;
		res.base_prio = rec.base_prio;
		res.run_prio  = prio[7:0];
		res.time_left = rec.time_left;
		res.policy    = rec.policy;
		res.quantum   = slice[13:0];
		return res;
	endfunction

	function automatic request_t random_request(input int enq_pct);
		request_t r;
		r.req_type    = ($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DISP;
		r.task_id     = $urandom;
		// Mostly legal static priorities, some above the top of the range.
		r.base_prio   = ($urandom_range(9) < 8) ? $urandom_range(139) : $urandom_range(255);
		// Bias toward high dynamic priorities so that the bonus saturates.
		r.run_prio    = ($urandom_range(3) == 0) ? $urandom_range(255, 230) : $urandom_range(255);
		r.time_left   = $urandom;
		r.policy_kind = $urandom_range(3);
		r.exec_time   = $urandom;
		return r;
	endfunction

	function void compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Present one request and hold it until it is accepted, then record the
	// expected result.
	task automatic issue(input request_t r, input bit typed, input result_t typed_res);
		result_t res;
		start       <= 1'b1;
		req_type    <= r.req_type;
		task_id     <= r.task_id;
		base_prio   <= r.base_prio;
		run_prio    <= r.run_prio;
		time_left   <= r.time_left;
		policy_kind <= r.policy_kind;
		exec_time   <= r.exec_time;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		res = schedule_request(r);
		pending_results.push_back(typed ? typed_res : res);
	endtask

	task automatic sender_gap(input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop sending and wait until every outstanding request has answered.
	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(input logic [2:0] idx, input logic [7:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		case (idx)
			REG_LEVEL0_LIMIT:  sched_regs.level0_limit  = val;
			REG_LEVEL1_LIMIT:  sched_regs.level1_limit  = val;
			REG_LONG_Q_LIMIT:  sched_regs.long_q_limit  = val;
			REG_LARGE_UNIT:    sched_regs.large_unit    = val[5:0];
			REG_SMALL_UNIT:    sched_regs.small_unit    = val[5:0];
			REG_FULL_BONUS:    sched_regs.full_bonus    = val[4:0];
			REG_PARTIAL_BONUS: sched_regs.partial_bonus = val[4:0];
			default: ;
		endcase
	endtask

	// Load all seven scheduling registers and write the unused index; only called while the block is idle.
	task automatic load_settings(input settings_kind_e kind);
		logic [7:0] vals [7];
		foreach (vals[i]) begin
			case (kind)
				CFG_MAX:  vals[i] = 8'hff;
				CFG_ZERO: vals[i] = 8'h00;
				default:  vals[i] = (i < 3) ? $urandom_range(150) : $urandom_range(255);
			endcase
		end
		if (kind == CFG_FILL) begin
			vals[0] = 8'h00;
			vals[1] = 8'h00;
		end
		set_register(REG_LEVEL0_LIMIT, vals[0]);
		set_register(REG_LEVEL1_LIMIT, vals[1]);
		set_register(REG_LONG_Q_LIMIT, vals[2]);
		set_register(REG_LARGE_UNIT, vals[3]);
		set_register(REG_SMALL_UNIT, vals[4]);
		set_register(REG_FULL_BONUS, vals[5]);
		set_register(REG_PARTIAL_BONUS, vals[6]);
		set_register(REG_UNUSED, $urandom_range(255));
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Result checker: every strobed result must match the oldest expectation.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			got = '{status, level, out_task_id, out_base_prio, out_run_prio,
				out_time_left, out_policy, quantum};
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got %h", $time, got);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("status", want.status, got.status);
				compare_field("level", want.level, got.level);
				compare_field("out_task_id", want.task_id, got.task_id);
				compare_field("out_base_prio", want.base_prio, got.base_prio);
				compare_field("out_run_prio", want.run_prio, got.run_prio);
				compare_field("out_time_left", want.time_left, got.time_left);
				compare_field("out_policy", want.policy, got.policy);
				compare_field("quantum", want.quantum, got.quantum);
			end
		end
	end

	// Overall time limit, far above the slowest correct run.
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Main sequence: reset, directed table, random phases, final check.
	initial begin
		fail_count  = 0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		req_type    <= REQ_ENQ;
		task_id     <= '0;
		base_prio   <= '0;
		run_prio    <= '0;
		time_left   <= '0;
		policy_kind <= '0;
		exec_time   <= '0;
		wr_en       <= 1'b0;
		wr_index    <= REG_LEVEL0_LIMIT;
		wr_data     <= '0;
		sched_regs  = '{RST_LEVEL0_LIMIT, RST_LEVEL1_LIMIT, RST_LONG_Q_LIMIT,
			RST_LARGE_UNIT, RST_SMALL_UNIT, RST_FULL_BONUS, RST_PARTIAL_BONUS};
		for (int l = 0; l < NUM_LEVELS; l++) begin
			head_slot[l]  = 0;
			tail_slot[l]  = 0;
			fill_level[l] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		settle();

		foreach (phases[p]) begin
			if (phases[p].kind != CFG_KEEP)
				load_settings(phases[p].kind);
			for (int i = 0; i < phases[p].count; i++) begin
				// Once in the last phase, let the block drain completely.
				if (p == N_PHASES - 1 && i == phases[p].count / 2)
					settle();
				sender_gap(phases[p].idle_pct);
				issue(random_request(phases[p].enq_pct), 1'b0, '0);
			end
			settle();
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
